// File: src/safs_pkg.sv
// Package for the slot allocator with a free stack.
// Holds the sizes, command and status codes, controller state and command struct.
// No dependencies.
package safs_pkg;

	localparam int SLOTS   = 256;
	localparam int VALUE_W = 32;
	localparam int SLOT_W  = $clog2(SLOTS);
	localparam int CNT_W   = $clog2(SLOTS + 1);

	typedef enum logic {
		CMD_ADD    = 1'b0,
		CMD_REMOVE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		STATUS_ADDED   = 2'd0,
		STATUS_REMOVED = 2'd1,
		STATUS_FULL    = 2'd2,
		STATUS_BAD     = 2'd3
	} status_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} ctl_state_t;

	typedef struct packed {
		logic load;
		logic commit;
	} dp_cmd_t;

endpackage

// File: src/safs_if.sv
// Handshake interfaces for the request and response channels.
// Depends on safs_pkg for the field widths.
interface alloc_req_if import safs_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              cmd;
	logic [VALUE_W-1:0] elem_value;
	logic [SLOT_W-1:0]  slot_index;

	modport source (output valid, cmd, elem_value, slot_index, input ready);
	modport sink (input valid, cmd, elem_value, slot_index, output ready);
endinterface

interface alloc_rsp_if import safs_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [SLOT_W-1:0]  slot_out;
	logic [1:0]         status;
	logic [VALUE_W-1:0] released_value;
	logic [CNT_W-1:0]   element_count;

	modport source (output valid, slot_out, status, released_value, element_count,
		input ready);
	modport sink (input valid, slot_out, status, released_value, element_count,
		output ready);
endinterface

// File: src/safs_ctrl.sv
// Controller for the slot allocator: request acceptance, execute step, result valid.
// Depends on safs_pkg for the state type and the datapath command struct.
module safs_ctrl import safs_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	output logic    req_ready,
	output logic    rsp_valid,
	input  logic    rsp_ready,
	output dp_cmd_t dp_cmd
);

	ctl_state_t state_q, state_d;
	logic       rsp_valid_q, rsp_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		rsp_valid_d   = rsp_valid_q && !rsp_ready;
		req_ready     = 1'b0;
		dp_cmd.load   = 1'b0;
		dp_cmd.commit = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					dp_cmd.load = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				// hold until the result register is free
				if (!rsp_valid_q || rsp_ready) begin
					dp_cmd.commit = 1'b1;
					rsp_valid_d   = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;

endmodule

// File: src/safs_datapath.sv
// Datapath for the slot allocator: slot memory, free stack memory, valid bits,
// counters and the result register. Depends on safs_pkg.
module safs_datapath import safs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            dp_cmd,
	input  logic               req_cmd,
	input  logic [VALUE_W-1:0] req_value,
	input  logic [SLOT_W-1:0]  req_slot,
	output logic [SLOT_W-1:0]  slot_out,
	output logic [1:0]         status,
	output logic [VALUE_W-1:0] released_value,
	output logic [CNT_W-1:0]   element_count
);

	logic [VALUE_W-1:0] slot_store [SLOTS];
	logic [SLOT_W-1:0]  free_stack [SLOTS];
	logic [SLOTS-1:0]   slot_valid_q;

	logic [CNT_W-1:0]   free_depth_q, high_water_q, occ_q;
	logic [CNT_W-1:0]   free_depth_d, high_water_d, occ_d;
	logic [CNT_W-1:0]   stack_top;

	logic               cmd_q;
	logic [VALUE_W-1:0] value_q;
	logic [SLOT_W-1:0]  idx_q;
	logic [SLOT_W-1:0]  stack_rd_q;
	logic [VALUE_W-1:0] held_q;

	logic               add_ok, rem_ok;
	logic [SLOT_W-1:0]  slot_d;
	status_t            status_d;
	logic [VALUE_W-1:0] released_d;

	assign stack_top = free_depth_q - CNT_W'(1);

	always_ff @(posedge clk) begin
		if (dp_cmd.load) begin
			cmd_q      <= req_cmd;
			value_q    <= req_value;
			idx_q      <= req_slot;
			stack_rd_q <= free_stack[stack_top[SLOT_W-1:0]];
			held_q     <= slot_store[req_slot];
		end
		if (dp_cmd.commit && add_ok) begin
			slot_store[slot_d] <= value_q;
		end
		if (dp_cmd.commit && rem_ok && (free_depth_q < CNT_W'(SLOTS))) begin
			free_stack[free_depth_q[SLOT_W-1:0]] <= idx_q;
		end
		if (dp_cmd.commit) begin
			slot_out       <= slot_d;
			status         <= status_d;
			released_value <= released_d;
			element_count  <= occ_d;
		end
	end

	always_comb begin
		add_ok       = 1'b0;
		rem_ok       = 1'b0;
		slot_d       = '0;
		status_d     = STATUS_FULL;
		released_d   = '0;
		free_depth_d = free_depth_q;
		high_water_d = high_water_q;
		occ_d        = occ_q;
		if (cmd_q == CMD_ADD) begin
			if (free_depth_q != '0) begin
				add_ok       = 1'b1;
				slot_d       = stack_rd_q;
				free_depth_d = stack_top;
			end else if (high_water_q < CNT_W'(SLOTS)) begin
				add_ok       = 1'b1;
				slot_d       = high_water_q[SLOT_W-1:0];
				high_water_d = high_water_q + CNT_W'(1);
			end
			if (add_ok) begin
				status_d = STATUS_ADDED;
				occ_d    = occ_q + CNT_W'(1);
			end
		end else begin
			slot_d = idx_q;
			if (({1'b0, idx_q} >= high_water_q) || !slot_valid_q[idx_q]) begin
				status_d = STATUS_BAD;
			end else begin
				rem_ok     = 1'b1;
				status_d   = STATUS_REMOVED;
				released_d = held_q;
				if (occ_q != '0) begin
					occ_d = occ_q - CNT_W'(1);
				end
				if (free_depth_q < CNT_W'(SLOTS)) begin
					free_depth_d = free_depth_q + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			free_depth_q <= '0;
			high_water_q <= '0;
			occ_q        <= '0;
		end else if (dp_cmd.commit) begin
			free_depth_q <= free_depth_d;
			high_water_q <= high_water_d;
			occ_q        <= occ_d;
			if (add_ok) begin
				slot_valid_q[slot_d] <= 1'b1;
			end
			if (rem_ok) begin
				slot_valid_q[idx_q] <= 1'b0;
			end
		end
	end

endmodule

// File: src/slot_allocator_free_stack_core.sv
// Slot allocator with LIFO free stack: add stores a value and returns a slot,
// remove frees a slot and returns its value.
// Request fields are captured and memories read at transfer; the execute state commits the update
// and result once the result register is free. Requests are taken only when idle, one at a time.
// Reset clears valid bits and counters at once; memories are not cleared.
// Depends on safs_pkg, safs_if, safs_ctrl and safs_datapath.
module slot_allocator_free_stack_core import safs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	alloc_req_if.sink   req,
	alloc_rsp_if.source rsp
);

	dp_cmd_t dp_cmd;

	safs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.dp_cmd    (dp_cmd)
	);

	safs_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.dp_cmd         (dp_cmd),
		.req_cmd        (req.cmd),
		.req_value      (req.elem_value),
		.req_slot       (req.slot_index),
		.slot_out       (rsp.slot_out),
		.status         (rsp.status),
		.released_value (rsp.released_value),
		.element_count  (rsp.element_count)
	);

endmodule
